// ===== rtl/frt_pkg.sv =====
// ============================================================================
// Free range table package
// Shared constants, codes and the structs that pass between the table cells
// and the top-level controller.
// ============================================================================
package frt_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_LIST  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FREE  = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_LIST
  } state_t;

  typedef enum logic [3:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_EVAL,
    CELL_ROTATE,
    CELL_ALLOC_DEL,
    CELL_ALLOC_FRONT,
    CELL_ALLOC_BACK,
    CELL_ALLOC_SPLIT,
    CELL_FREE_MERGE,
    CELL_FREE_PREV,
    CELL_FREE_NEXT,
    CELL_FREE_INSERT
  } cell_op_t;

  typedef struct packed {
    logic v;
    logic lt;
    logic hit;
    logic gt;
  } cell_link_t;

  typedef struct packed {
    logic hit;
    logic fit;
    logic ss;
    logic seq;
    logic ovl;
    logic padj;
    logic nadj;
  } cell_stat_t;

endpackage

// ===== rtl/free_range_table.sv =====
// Allocate and free: the result enters the output register after a compare step in every
// cell (S_EVAL) and an update step (S_APPLY); a new request is taken only back in S_IDLE.
// Unused action code: goes straight to S_APPLY and skips the compare step.
// List: results come from the head cell as the chain rotates, one per cycle while the
// output is not stalled. An output stall holds the state machine in its state.
// Reset and a write of total_length give one free segment at once, no clearing pass.
// ============================================================================
// Free range table
// Sorted table of free address ranges held in a chain of cells, with
// allocate, free with coalescing, and listing of all free segments.
// ============================================================================
module free_range_table
  import frt_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // range_start, range_length
  input  logic [((2*ADDR_BITS+8)/8)*8-1:0]       in_tdata,
  // action
  input  logic [1:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // status, seg_start, seg_length
  output logic [((2*ADDR_BITS+10)/8)*8-1:0]      out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ADDR_BITS:0]                     cfg_data
);

  localparam int AW = ADDR_BITS;
  localparam int LW = ADDR_BITS + 1;
  localparam int EW = ADDR_BITS + 2;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int OW = ((2*ADDR_BITS+10)/8)*8;
  localparam logic [LW-1:0] SPACE    = {1'b1, {AW{1'b0}}};
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SEGMENTS);

  state_t         state_r, state_nxt;
  action_t        act_r;
  logic [AW-1:0]  s_r;
  logic [LW-1:0]  len_r;
  logic [EW-1:0]  end_r;
  logic [LW-1:0]  total_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;

  logic           out_valid_r;
  status_t        out_status_r, out_status_nxt;
  logic [AW-1:0]  out_st_r, out_st_nxt;
  logic [LW-1:0]  out_ln_r, out_ln_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_load;

  logic           in_acc, cfg_acc, out_free, last_item;
  logic [LW-1:0]  cfg_sat;
  cell_op_t       cell_op, apply_op;
  status_t        apply_status;
  cell_stat_t     red;

  cell_link_t     c_link [MAX_SEGMENTS];
  cell_stat_t     c_stat [MAX_SEGMENTS];
  logic [AW-1:0]  c_st   [MAX_SEGMENTS];
  logic [LW-1:0]  c_ln   [MAX_SEGMENTS];
  logic [LW-1:0]  c_se   [MAX_SEGMENTS];

  assign in_acc    = in_tvalid & in_tready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign out_free  = ~out_valid_r | out_tready;
  assign last_item = CW'(idx_r + CW'(1)) == count_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_sat = LW'(1);
    end else if (cfg_data > SPACE) begin
      cfg_sat = SPACE;
    end else begin
      cfg_sat = cfg_data;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      cell_link_t    l_link, r_link;
      logic [AW-1:0] l_st, r_st;
      logic [LW-1:0] l_ln, r_ln, l_se, r_se;

      if (g == 0) begin : g_left_edge
        assign l_link = '0;
        assign l_st   = '0;
        assign l_ln   = '0;
        assign l_se   = '0;
      end else begin : g_left
        assign l_link = c_link[g-1];
        assign l_st   = c_st[g-1];
        assign l_ln   = c_ln[g-1];
        assign l_se   = c_se[g-1];
      end

      if (g == MAX_SEGMENTS - 1) begin : g_right_edge
        assign r_link = '0;
        assign r_st   = '0;
        assign r_ln   = '0;
        assign r_se   = '0;
      end else begin : g_right
        assign r_link = c_link[g+1];
        assign r_st   = c_st[g+1];
        assign r_ln   = c_ln[g+1];
        assign r_se   = c_se[g+1];
      end

      frt_cell #(
        .ADDR_BITS (ADDR_BITS)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .is_head    (g == 0),
        .op         (cell_op),
        .s_addr     (s_r),
        .len        (len_r),
        .end_addr   (end_r),
        .init_len   (cfg_sat),
        .left_link  (l_link),
        .left_st    (l_st),
        .left_ln    (l_ln),
        .left_se    (l_se),
        .right_link (r_link),
        .right_st   (r_st),
        .right_ln   (r_ln),
        .right_se   (r_se),
        .head_st    (c_st[0]),
        .head_ln    (c_ln[0]),
        .link       (c_link[g]),
        .st         (c_st[g]),
        .ln         (c_ln[g]),
        .se         (c_se[g]),
        .stat       (c_stat[g])
      );
    end
  endgenerate

  always_comb begin
    red = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      red = cell_stat_t'(red | c_stat[i]);
    end
  end

  always_comb begin
    apply_status = ST_OK;
    apply_op     = CELL_HOLD;
    case (act_r)
      ACT_ALLOC: begin
        if (!red.hit || len_r == '0 || !red.fit) begin
          apply_status = ST_NOT_FREE;
        end else if (red.ss && red.seq) begin
          apply_op = CELL_ALLOC_DEL;
        end else if (red.ss) begin
          apply_op = CELL_ALLOC_FRONT;
        end else if (red.seq) begin
          apply_op = CELL_ALLOC_BACK;
        end else if (count_r == FULL_CNT) begin
          apply_status = ST_FULL;
        end else begin
          apply_op = CELL_ALLOC_SPLIT;
        end
      end
      ACT_FREE: begin
        if (len_r == '0 || end_r > {1'b0, total_r} || red.ovl) begin
          apply_status = ST_BAD_RANGE;
        end else if (red.padj && red.nadj) begin
          apply_op = CELL_FREE_MERGE;
        end else if (red.padj) begin
          apply_op = CELL_FREE_PREV;
        end else if (red.nadj) begin
          apply_op = CELL_FREE_NEXT;
        end else if (count_r == FULL_CNT) begin
          apply_status = ST_FULL;
        end else begin
          apply_op = CELL_FREE_INSERT;
        end
      end
      default: begin
        apply_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_tuser))
            ACT_ALLOC: state_nxt = S_EVAL;
            ACT_FREE:  state_nxt = S_EVAL;
            ACT_LIST:  state_nxt = S_LIST;
            default:   state_nxt = S_APPLY;
          endcase
        end
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && (count_r == '0 || last_item)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cfg_ready      = 1'b0;
    cell_op        = CELL_HOLD;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_st_nxt     = '0;
    out_ln_nxt     = '0;
    out_last_nxt   = 1'b1;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = ~cfg_valid;
        idx_nxt   = '0;
        if (cfg_acc) begin
          cell_op   = CELL_INIT;
          count_nxt = CW'(1);
        end
      end
      S_EVAL: begin
        cell_op = CELL_EVAL;
      end
      S_APPLY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = apply_status;
          cell_op        = apply_op;
          if (apply_op == CELL_ALLOC_DEL || apply_op == CELL_FREE_MERGE) begin
            count_nxt = count_r - CW'(1);
          end else if (apply_op == CELL_ALLOC_SPLIT || apply_op == CELL_FREE_INSERT) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_r != '0) begin
            out_st_nxt   = c_st[0];
            out_ln_nxt   = c_ln[0];
            out_last_nxt = last_item;
            cell_op      = CELL_ROTATE;
            idx_nxt      = CW'(idx_r + CW'(1));
          end
        end
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      idx_r       <= '0;
      total_r     <= SPACE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_load | (out_valid_r & ~out_tready);
      if (cfg_acc) begin
        total_r <= cfg_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= action_t'(in_tuser);
      s_r   <= in_tdata[AW-1:0];
      len_r <= in_tdata[2*AW:AW];
      end_r <= {2'b00, in_tdata[AW-1:0]} + {1'b0, in_tdata[2*AW:AW]};
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_st_r     <= out_st_nxt;
      out_ln_r     <= out_ln_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_ln_r, out_st_r, out_status_r});
  assign out_tlast  = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("Segment count exceeds the table depth.");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_link[0].v == (count_r != '0))
    else $error("Head cell occupancy disagrees with the segment count.");

  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_link[MAX_SEGMENTS-1].v == (count_r == FULL_CNT))
    else $error("Tail cell occupancy disagrees with the segment count.");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST && out_free && count_r != '0 && last_item) |=>
      (out_tlast && c_link[0].v))
    else $error("List transaction ended without the final marker.");

endmodule

// ===== rtl/frt_cell.sv =====
// ============================================================================
// Free range table cell
// Holds one free segment, compares it against the broadcast range and
// shifts, trims or takes segments from its neighbors on command.
// ============================================================================
module frt_cell
  import frt_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 is_head,
  input  cell_op_t             op,
  input  logic [ADDR_BITS-1:0] s_addr,
  input  logic [ADDR_BITS:0]   len,
  input  logic [ADDR_BITS+1:0] end_addr,
  input  logic [ADDR_BITS:0]   init_len,
  input  cell_link_t           left_link,
  input  logic [ADDR_BITS-1:0] left_st,
  input  logic [ADDR_BITS:0]   left_ln,
  input  logic [ADDR_BITS:0]   left_se,
  input  cell_link_t           right_link,
  input  logic [ADDR_BITS-1:0] right_st,
  input  logic [ADDR_BITS:0]   right_ln,
  input  logic [ADDR_BITS:0]   right_se,
  input  logic [ADDR_BITS-1:0] head_st,
  input  logic [ADDR_BITS:0]   head_ln,
  output cell_link_t           link,
  output logic [ADDR_BITS-1:0] st,
  output logic [ADDR_BITS:0]   ln,
  output logic [ADDR_BITS:0]   se,
  output cell_stat_t           stat
);

  localparam int LW = ADDR_BITS + 1;

  logic                 v_r, v_nxt;
  logic [ADDR_BITS-1:0] st_r, st_nxt;
  logic [LW-1:0]        ln_r, ln_nxt;
  logic [LW-1:0]        se_r;
  logic                 lt_r, hit_r, gt_r, ovl_r, fit_r, ss_r, seq_r, padj_r, nadj_r;

  logic [LW-1:0]        se_c;
  logic [LW-1:0]        s_x;
  logic                 pos, bnd;

  assign se_c = {1'b0, st_r} + ln_r;
  assign s_x  = {1'b0, s_addr};
  assign pos  = ~lt_r & (is_head | left_link.lt);
  assign bnd  = lt_r & ~right_link.lt;

  always_comb begin
    v_nxt  = v_r;
    st_nxt = st_r;
    ln_nxt = ln_r;
    case (op)
      CELL_INIT: begin
        v_nxt  = is_head;
        st_nxt = '0;
        ln_nxt = init_len;
      end
      CELL_ROTATE: begin
        if (right_link.v) begin
          st_nxt = right_st;
          ln_nxt = right_ln;
        end else if (v_r) begin
          st_nxt = head_st;
          ln_nxt = head_ln;
        end
      end
      CELL_ALLOC_DEL: begin
        if (hit_r || gt_r) begin
          v_nxt  = right_link.v;
          st_nxt = right_st;
          ln_nxt = right_ln;
        end
      end
      CELL_ALLOC_FRONT: begin
        if (hit_r) begin
          st_nxt = end_addr[ADDR_BITS-1:0];
          ln_nxt = ln_r - len;
        end
      end
      CELL_ALLOC_BACK: begin
        if (hit_r) begin
          ln_nxt = ln_r - len;
        end
      end
      CELL_ALLOC_SPLIT: begin
        if (hit_r) begin
          ln_nxt = s_x - {1'b0, st_r};
        end else if (left_link.hit) begin
          v_nxt  = 1'b1;
          st_nxt = end_addr[ADDR_BITS-1:0];
          ln_nxt = left_se - end_addr[LW-1:0];
        end else if (left_link.gt) begin
          v_nxt  = left_link.v;
          st_nxt = left_st;
          ln_nxt = left_ln;
        end
      end
      CELL_FREE_MERGE: begin
        if (bnd) begin
          ln_nxt = right_se - {1'b0, st_r};
        end else if (v_r && !lt_r) begin
          v_nxt  = right_link.v;
          st_nxt = right_st;
          ln_nxt = right_ln;
        end
      end
      CELL_FREE_PREV: begin
        if (bnd) begin
          ln_nxt = ln_r + len;
        end
      end
      CELL_FREE_NEXT: begin
        if (v_r && pos) begin
          st_nxt = s_addr;
          ln_nxt = ln_r + len;
        end
      end
      CELL_FREE_INSERT: begin
        if (pos) begin
          v_nxt  = 1'b1;
          st_nxt = s_addr;
          ln_nxt = len;
        end else if (!lt_r) begin
          v_nxt  = left_link.v;
          st_nxt = left_st;
          ln_nxt = left_ln;
        end
      end
      default: begin
        v_nxt  = v_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= is_head;
      st_r <= '0;
      ln_r <= {1'b1, {ADDR_BITS{1'b0}}};
    end else begin
      v_r  <= v_nxt;
      st_r <= st_nxt;
      ln_r <= ln_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == CELL_EVAL) begin
      se_r   <= se_c;
      lt_r   <= v_r & (st_r < s_addr);
      gt_r   <= v_r & (st_r > s_addr);
      hit_r  <= v_r & (st_r <= s_addr) & (s_x < se_c);
      ovl_r  <= v_r & (s_x < se_c) & ({2'b00, st_r} < end_addr);
      fit_r  <= end_addr <= {1'b0, se_c};
      ss_r   <= st_r == s_addr;
      seq_r  <= end_addr == {1'b0, se_c};
      padj_r <= se_c == s_x;
      nadj_r <= {2'b00, st_r} == end_addr;
    end
  end

  always_comb begin
    link.v   = v_r;
    link.lt  = lt_r;
    link.hit = hit_r;
    link.gt  = gt_r;
    stat.hit  = hit_r;
    stat.fit  = hit_r & fit_r;
    stat.ss   = hit_r & ss_r;
    stat.seq  = hit_r & seq_r;
    stat.ovl  = ovl_r;
    stat.padj = bnd & padj_r;
    stat.nadj = v_r & pos & nadj_r;
  end

  assign st = st_r;
  assign ln = ln_r;
  assign se = se_r;

endmodule

// ===== tb/tb_free_range_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Free range table testbench
// Sends allocate, free, list and unused-code requests through the input stream and
// tracks its own copy of the free segment table. Every result transaction is checked
// in order against the response predicted from that copy or given by a directed row.
// The run starts with a directed table, then moves on to random requests under several
// space sizes and idle and stall patterns.
// ============================================================================
module tb_free_range_table
  import frt_pkg::*;
();

  localparam int TAB_DEPTH         = 16;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int ITEMS_PER_SETTING = 13;

  typedef struct packed {
    status_t     status;
    logic [15:0] seg_start;
    logic [16:0] seg_length;
    logic        last;
  } seg_report_t;

  typedef struct {
    bit          is_cfg;
    action_t     act;
    logic [15:0] start;
    logic [16:0] len;
    bit          typed;
    seg_report_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  seg_report_t pending_results[$];
  stim_row_t   directed_rows[$];

  logic [15:0] free_start[TAB_DEPTH];
  logic [16:0] free_len[TAB_DEPTH];
  int          free_cnt;
  logic [16:0] space_len;

  int idle_pct;
  int stall_pct;
  int mismatch_cnt;
  int result_cnt;
  int cfg_cnt;
  int idle_cycles;
  int act_cnt[4];

  free_range_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic seg_report_t report(input status_t st, input logic [15:0] ss,
                                         input logic [16:0] sl, input logic last);
    seg_report_t r;
    r.status     = st;
    r.seg_start  = ss;
    r.seg_length = sl;
    r.last       = last;
    return r;
  endfunction

  function automatic void table_reset(input logic [16:0] len);
    space_len     = len;
    free_start[0] = '0;
    free_len[0]   = len;
    free_cnt      = 1;
  endfunction

  function automatic void drop_entry(input int pos);
    for (int j = pos; j + 1 < free_cnt; j++) begin
      free_start[j] = free_start[j + 1];
      free_len[j]   = free_len[j + 1];
    end
    free_cnt--;
  endfunction

  function automatic void add_entry(input int pos, input int unsigned st,
                                    input int unsigned ln);
    for (int j = free_cnt; j > pos; j--) begin
      free_start[j] = free_start[j - 1];
      free_len[j]   = free_len[j - 1];
    end
    free_start[pos] = 16'(st);
    free_len[pos]   = 17'(ln);
    free_cnt++;
  endfunction

  function automatic status_t alloc_status(input int unsigned s, input int unsigned l);
    int unsigned st;
    int unsigned se;
    int unsigned e;
    e = s + l;
    for (int i = 0; i < free_cnt; i++) begin
      st = free_start[i];
      se = st + free_len[i];
      if (st <= s && s < se) begin
        if (l == 0 || e > se) return ST_NOT_FREE;
        if (s == st && e == se) begin
          drop_entry(i);
        end else if (s == st) begin
          free_start[i] = 16'(e);
          free_len[i]   = 17'(se - e);
        end else if (e == se) begin
          free_len[i] = 17'(s - st);
        end else begin
          if (free_cnt >= TAB_DEPTH) return ST_FULL;
          add_entry(i + 1, e, se - e);
          free_len[i] = 17'(s - st);
        end
        return ST_OK;
      end
    end
    return ST_NOT_FREE;
  endfunction

  function automatic status_t free_status(input int unsigned s, input int unsigned l);
    int unsigned st;
    int unsigned e;
    int          p;
    bit          prev_adj;
    bit          next_adj;
    e = s + l;
    p = 0;
    if (l == 0 || e > space_len) return ST_BAD_RANGE;
    for (int i = 0; i < free_cnt; i++) begin
      st = free_start[i];
      if (s < st + free_len[i] && st < e) return ST_BAD_RANGE;
      if (st < s) p = i + 1;
    end
    prev_adj = p > 0 && (int'(free_start[p - 1]) + int'(free_len[p - 1]) == s);
    next_adj = p < free_cnt && (int'(free_start[p]) == e);
    if (prev_adj && next_adj) begin
      free_len[p - 1] = 17'(free_len[p - 1] + l + free_len[p]);
      drop_entry(p);
    end else if (prev_adj) begin
      free_len[p - 1] = 17'(free_len[p - 1] + l);
    end else if (next_adj) begin
      free_start[p] = 16'(s);
      free_len[p]   = 17'(free_len[p] + l);
    end else begin
      if (free_cnt >= TAB_DEPTH) return ST_FULL;
      add_entry(p, s, l);
    end
    return ST_OK;
  endfunction

  function automatic void predict_response(input action_t act, input logic [15:0] s,
                                           input logic [16:0] l);
    case (act)
      ACT_ALLOC: pending_results.push_back(report(alloc_status(s, l), '0, '0, 1'b1));
      ACT_FREE:  pending_results.push_back(report(free_status(s, l), '0, '0, 1'b1));
      ACT_LIST: begin
        if (free_cnt == 0) begin
          pending_results.push_back(report(ST_OK, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < free_cnt; i++)
            pending_results.push_back(report(ST_OK, free_start[i], free_len[i],
                                             i + 1 == free_cnt));
        end
      end
      default: pending_results.push_back(report(ST_OK, '0, '0, 1'b1));
    endcase
  endfunction

  function automatic void row(input bit is_cfg, input action_t act, input logic [15:0] s,
                              input logic [16:0] l, input bit typed, input status_t st,
                              input logic [15:0] ss, input logic [16:0] sl);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.act    = act;
    r.start  = s;
    r.len    = l;
    r.typed  = typed;
    r.want   = report(st, ss, sl, 1'b1);
    directed_rows.push_back(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(input action_t act, input logic [15:0] s,
                              input logic [16:0] l, input bit typed,
                              input seg_report_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {7'd0, l, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_response(act, s, l);
    if (typed) pending_results[$] = want;
    act_cnt[act]++;
    @(negedge clk);
  endtask

  task automatic write_space(input logic [16:0] v);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    table_reset(v == 17'd0 ? 17'd1 : (v > 17'h10000 ? 17'h10000 : v));
    cfg_cnt++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_request(output action_t act, output logic [15:0] s,
                                output logic [16:0] l);
    int unsigned gap_s[TAB_DEPTH + 1];
    int unsigned gap_l[TAB_DEPTH + 1];
    int unsigned prev_end;
    int unsigned base;
    int unsigned span;
    int unsigned sub;
    int unsigned off;
    int          n_gap;
    int          k;
    int          r;
    r    = $urandom_range(99);
    s    = 16'($urandom_range(65535));
    l    = 17'($urandom_range(65536));
    span = 0;
    base = 0;
    if (r < 5) begin
      act = ACT_NONE;
    end else if (r < 20) begin
      act = ACT_LIST;
    end else if (r < 60) begin
      act = ACT_ALLOC;
      if (free_cnt > 0 && $urandom_range(9) < 8) begin
        k    = $urandom_range(free_cnt - 1);
        base = free_start[k];
        span = free_len[k];
      end
    end else begin
      act      = ACT_FREE;
      n_gap    = 0;
      prev_end = 0;
      for (int i = 0; i < free_cnt; i++) begin
        if (free_start[i] > prev_end) begin
          gap_s[n_gap] = prev_end;
          gap_l[n_gap] = free_start[i] - prev_end;
          n_gap++;
        end
        prev_end = free_start[i] + free_len[i];
      end
      if (space_len > prev_end) begin
        gap_s[n_gap] = prev_end;
        gap_l[n_gap] = space_len - prev_end;
        n_gap++;
      end
      if (n_gap > 0 && $urandom_range(9) < 8) begin
        k    = $urandom_range(n_gap - 1);
        base = gap_s[k];
        span = gap_l[k];
      end
    end
    if (span != 0) begin
      case ($urandom_range(3))
        0: begin
          sub = span;
          off = 0;
        end
        1: begin
          sub = $urandom_range(span, 1);
          off = 0;
        end
        2: begin
          sub = $urandom_range(span, 1);
          off = span - sub;
        end
        default: begin
          sub = $urandom_range(span > 8 ? span / 4 : span, 1);
          off = $urandom_range(span - sub, 0);
        end
      endcase
      // A few requests run one address past the chosen range.
      if ($urandom_range(9) == 0 && sub < 65536) sub++;
      s = 16'(base + off);
      l = 17'(sub);
    end
  endtask

  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : result_check
    seg_report_t got;
    seg_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = report(status_t'(out_tdata[1:0]), out_tdata[17:2], out_tdata[34:18],
                   out_tlast);
      result_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result status %0d start %0d length %0d last %0d",
                   $realtime, got.status, got.seg_start, got.seg_length, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch, expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     $realtime, want.status, want.seg_start, want.seg_length, want.last,
                     got.status, got.seg_start, got.seg_length, got.last);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          idle_sched[4];
    int          stall_sched[4];
    logic [16:0] space_sched[8];
    action_t     act;
    logic [15:0] s;
    logic [16:0] l;
    int          n;
    idle_sched  = '{0, 51, 0, 18};
    stall_sched = '{0, 0, 51, 18};
    space_sched = '{17'd0, 17'd60, 17'd1, 17'h1FFFF, 17'd37, 17'h10000, 17'd90, 17'd20};
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_ALLOC;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;
    result_cnt   = 0;
    cfg_cnt      = 0;
    act_cnt      = '{0, 0, 0, 0};
    table_reset(17'h10000);

    row(0, ACT_LIST,  16'd0,     17'd0,       1, ST_OK,        '0, 17'h10000);
    row(0, ACT_ALLOC, 16'd0,     17'd0,       1, ST_NOT_FREE,  '0, '0);
    row(0, ACT_FREE,  16'd0,     17'd0,       1, ST_BAD_RANGE, '0, '0);
    row(0, ACT_FREE,  16'd0,     17'd1,       1, ST_BAD_RANGE, '0, '0);
    row(0, ACT_NONE,  16'hFFFF,  17'h1FFFF,   1, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd0,     17'h10000,   1, ST_OK,        '0, '0);
    row(0, ACT_LIST,  16'd0,     17'd0,       1, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd5,     17'd1,       1, ST_NOT_FREE,  '0, '0);
    row(0, ACT_FREE,  16'hFFFF,  17'd2,       1, ST_BAD_RANGE, '0, '0);
    row(0, ACT_FREE,  16'hFFFF,  17'd1,       0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd100,   17'd10,      0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd110,   17'd5,       0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd90,    17'd10,      0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd200,   17'd20,      0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd115,   17'd85,      0, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd90,    17'd5,       0, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd210,   17'd10,      0, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd100,   17'd10,      0, ST_OK,        '0, '0);
    row(0, ACT_ALLOC, 16'd98,    17'd5,       1, ST_NOT_FREE,  '0, '0);
    row(0, ACT_FREE,  16'd99,    17'd2,       1, ST_BAD_RANGE, '0, '0);
    row(0, ACT_LIST,  16'd0,     17'd0,       0, ST_OK,        '0, '0);
    // Punch single-address holes until every entry of the table is in use.
    row(1, ACT_NONE,  16'd0,     17'd40,      0, ST_OK,        '0, '0);
    for (int i = 0; i < TAB_DEPTH - 1; i++)
      row(0, ACT_ALLOC, 16'(2 * i + 1), 17'd1, 0, ST_OK, '0, '0);
    row(0, ACT_ALLOC, 16'd33,    17'd1,       1, ST_FULL,      '0, '0);
    row(0, ACT_ALLOC, 16'd36,    17'd4,       0, ST_OK,        '0, '0);
    row(0, ACT_FREE,  16'd38,    17'd1,       1, ST_FULL,      '0, '0);
    row(0, ACT_LIST,  16'd0,     17'd0,       0, ST_OK,        '0, '0);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_space(directed_rows[i].len);
      else
        send_request(directed_rows[i].act, directed_rows[i].start, directed_rows[i].len,
                     directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct  = idle_sched[ph / 2];
      stall_pct = stall_sched[ph / 2];
      write_space(space_sched[ph]);
      n = 0;
      while (n < ITEMS_PER_SETTING) begin
        random_request(act, s, l);
        send_request(act, s, l, 1'b0, '0);
        if (act != ACT_NONE) n++;
      end
    end

    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d allocate, %0d free, %0d list and %0d unused-code requests,",
             act_cnt[ACT_ALLOC], act_cnt[ACT_FREE], act_cnt[ACT_LIST], act_cnt[ACT_NONE]);
    $display("%0d result transactions checked over %0d space size writes, %0d mismatches.",
             result_cnt, cfg_cnt, mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/frt_pkg.sv
rtl/frt_cell.sv
rtl/free_range_table.sv
tb/tb_free_range_table.sv
